### rtl/core/bf5_pkg.sv
`default_nettype none
package bf5_pkg;

   localparam int MAX_WIDTH     = 256;
   localparam int COL_BITS      = 8;
   localparam int DIM_BITS      = 9;
   localparam int MIN_DIM       = 5;
   localparam int RING_LINES    = 6;
   localparam int RING_BITS     = 3;
   localparam int STORE_DEPTH   = RING_LINES * MAX_WIDTH;
   localparam int ADDR_BITS     = RING_BITS + COL_BITS;
   localparam int SIGMA_SPATIAL = 100;
   localparam int SIGMA_RANGE   = 100;
   localparam int WEIGHT_BITS   = 16;
   localparam int WSHIFT        = 30 - WEIGHT_BITS;
   localparam int SP_SIZE       = 9;
   localparam int D2_BITS       = 4;
   localparam int SW_BITS       = 21;
   localparam int SWP_BITS      = 30;
   localparam int W_BITS        = 17;

   localparam logic [63:0] SPATIAL_DEN = 64'(2 * SIGMA_SPATIAL * SIGMA_SPATIAL);
   localparam logic [63:0] RANGE_DEN   = 64'(2 * SIGMA_RANGE * SIGMA_RANGE);
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
   localparam logic [63:0] FRAC_Q30    = ONE_Q30 - 64'd1;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;
   localparam logic OP_PIXEL         = 1'b0;
   localparam logic OP_FLUSH         = 1'b1;

   typedef logic [15:0] sp_rom_type [SP_SIZE];
   typedef logic [15:0] range_rom_type [256];

   typedef struct packed {
      logic               valid;
      logic               centre;
      logic [D2_BITS-1:0] d2;
   } tap_tag_type;

   function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      begin
         term = ONE_Q30;
         pos  = ONE_Q30;
         neg  = 64'd0;
         for (int i = 1; i <= 24; i++) begin
            term = ((term * f) >> 30) / 64'(i);
            if (i % 2 == 1) neg = neg + term;
            else pos = pos + term;
         end
         return (pos > neg) ? pos - neg : 64'd0;
      end
   endfunction

   // exp(-n/den) in Q15, den picked from the two sigma constants
   function automatic logic [15:0] gauss_q15(input logic [63:0] n, input logic use_range);
      logic [63:0] den;
      logic [63:0] t;
      logic [63:0] k;
      logic [63:0] v;
      logic [63:0] e1;
      logic [63:0] r;
      begin
         den = use_range ? RANGE_DEN : SPATIAL_DEN;
         if (n >= 64'd12 * den) return 16'd0;
         t  = use_range ? (n << 30) / RANGE_DEN : (n << 30) / SPATIAL_DEN;
         k  = t >> 30;
         v  = exp_neg_q30(t & FRAC_Q30);
         e1 = exp_neg_q30(ONE_Q30);
         for (int j = 0; j < 16; j++) begin
            if (64'(j) < k) v = (v * e1 + (ONE_Q30 >> 1)) >> 30;
         end
         r = (v * 64'd32768 + (ONE_Q30 >> 1)) >> 30;
         return (r > 64'd32768) ? 16'd32768 : r[15:0];
      end
   endfunction

   function automatic sp_rom_type build_spatial();
      sp_rom_type rom;
      begin
         for (int i = 0; i < SP_SIZE; i++) rom[i] = gauss_q15(64'(i), 1'b0);
         return rom;
      end
   endfunction

   function automatic range_rom_type build_range();
      range_rom_type rom;
      begin
         for (int i = 0; i < 256; i++) rom[i] = gauss_q15(64'(i * i), 1'b1);
         return rom;
      end
   endfunction

   localparam sp_rom_type    SPATIAL_ROM = build_spatial();
   localparam range_rom_type RANGE_ROM   = build_range();

endpackage
`default_nettype wire

### rtl/core/bf5_line_store.sv
`default_nettype none
module bf5_line_store (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [bf5_pkg::ADDR_BITS-1:0] wr_addr,
   input  wire logic [7:0]                    wr_data,
   input  wire logic                          rd_en,
   input  wire logic [bf5_pkg::ADDR_BITS-1:0] rd_addr,
   output logic      [7:0]                    rd_data
);
   import bf5_pkg::*;

   logic [7:0] mem_ff [STORE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

### rtl/core/bf5_wsum.sv
`default_nettype none
module bf5_wsum (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         clear,
   input  wire bf5_pkg::tap_tag_type         tag,
   input  wire logic [7:0]                   rd_data,
   output logic                              busy,
   output logic      [bf5_pkg::SW_BITS-1:0]  sum_w,
   output logic      [bf5_pkg::SWP_BITS-1:0] sum_wp
);
   import bf5_pkg::*;

   logic [7:0]           centre_ff;
   logic                 v1_ff, v2_ff, v3_ff;
   logic [15:0]          ss_ff, rr_ff;
   logic [7:0]           p1_ff, p2_ff;
   logic [30:0]          prod_ff;
   logic [W_BITS-1:0]    w3_ff;
   logic [24:0]          wp3_ff;
   logic [SW_BITS-1:0]   sw_ff;
   logic [SWP_BITS-1:0]  swp_ff;
   logic [7:0]           diff;
   logic [W_BITS-1:0]    w_in;

   assign diff = (rd_data > centre_ff) ? rd_data - centre_ff : centre_ff - rd_data;
   assign w_in = prod_ff[WSHIFT +: W_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= tag.valid && !tag.centre;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tag.valid && tag.centre) centre_ff <= rd_data;
      ss_ff   <= SPATIAL_ROM[tag.d2];
      rr_ff   <= RANGE_ROM[diff];
      p1_ff   <= rd_data;
      prod_ff <= 31'(ss_ff * rr_ff);
      p2_ff   <= p1_ff;
      w3_ff   <= w_in;
      wp3_ff  <= 25'(w_in * p2_ff);
      if (clear) begin
         sw_ff  <= '0;
         swp_ff <= '0;
      end else if (v3_ff) begin
         sw_ff  <= sw_ff + SW_BITS'(w3_ff);
         swp_ff <= swp_ff + SWP_BITS'(wp3_ff);
      end
   end

   assign busy   = v1_ff || v2_ff || v3_ff;
   assign sum_w  = sw_ff;
   assign sum_wp = swp_ff;

endmodule
`default_nettype wire

### rtl/core/bf5_div.sv
`default_nettype none
module bf5_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [bf5_pkg::SWP_BITS-1:0] num,
   input  wire logic [bf5_pkg::SW_BITS-1:0]  den,
   output logic                              done,
   output logic      [7:0]                   quot
);
   import bf5_pkg::*;

   // quotient is a weighted mean of bytes, so eight restoring steps suffice
   logic [SWP_BITS-1:0]  rem_ff;
   logic [SW_BITS+6:0]   dsh_ff;
   logic [7:0]           q_ff;
   logic [3:0]           cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic                 fits;

   assign fits = SWP_BITS'(dsh_ff) <= rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 4'd8;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 4'd1;
            if (cnt_ff == 4'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num;
         dsh_ff <= {den, 7'd0};
         q_ff   <= '0;
      end else if (busy_ff) begin
         if (fits) rem_ff <= rem_ff - SWP_BITS'(dsh_ff);
         q_ff   <= {q_ff[6:0], fits};
         dsh_ff <= dsh_ff >> 1;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule
`default_nettype wire

### rtl/core/bilateral_filter_5x5.sv
`default_nettype none
// 5x5 bilateral filter on 8-bit grey pixels in raster order. Four-plus lines
// sit in a six-line ring memory; an output is due once the window below and to
// the right of it has arrived (2*width+2 pixels behind the input), and flush
// words (or pixels sent after a frame's last pixel) drain the tail. Each word
// that produces a result keeps the block busy through 26 reads of the single
// line-memory read port (centre plus 25 taps), a four-stage weight pipeline
// and an 8-step serial divider. Words that produce nothing are taken without
// leaving the idle state. A finished result waits in the output register
// while the next word is taken. Frame size is sampled at a frame's first
// pixel; width is clamped to 5..256 and height to at least 5. Edges mirror
// without repeating the border pixel.
module bilateral_filter_5x5 (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_op,
   input  wire logic [7:0] req_pixel,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic      [7:0] rsp_filtered,
   output logic            rsp_frame_end,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_index,
   input  wire logic [8:0] csr_wdata
);
   import bf5_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   function automatic logic [RING_BITS-1:0] ring_inc(input logic [RING_BITS-1:0] r);
      return (r == RING_BITS'(RING_LINES - 1)) ? '0 : r + 1'b1;
   endfunction

   function automatic logic [DIM_BITS-1:0] reflect_pos(input logic [DIM_BITS-1:0] pos,
                                                       input logic signed [3:0] off,
                                                       input logic [DIM_BITS-1:0] n);
      logic signed [DIM_BITS+1:0] x;
      logic signed [DIM_BITS+1:0] last;
      begin
         x    = $signed({2'b00, pos}) + $signed({{(DIM_BITS-2){off[3]}}, off});
         last = $signed({2'b00, n}) - 1;
         if (x < 0) x = -x;
         if (x > last) x = (last <<< 1) - x;
         return x[DIM_BITS-1:0];
      end
   endfunction

   logic [2:0]           state_ff, state_in;
   logic [DIM_BITS-1:0]  width_reg_ff, width_reg_in, height_reg_ff, height_reg_in;
   logic [DIM_BITS-1:0]  frame_w_ff, frame_w_in, frame_h_ff, frame_h_in;
   logic [DIM_BITS-1:0]  in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [COL_BITS-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [RING_BITS-1:0] in_ring_ff, in_ring_in, out_ring_ff, out_ring_in;
   logic [9:0]           pending_ff, pending_in;
   logic [DIM_BITS-1:0]  job_row_ff, job_row_in;
   logic [COL_BITS-1:0]  job_col_ff, job_col_in;
   logic [RING_BITS-1:0] job_ring_ff, job_ring_in;
   logic                 job_end_ff, job_end_in;
   logic                 centre_ph_ff, centre_ph_in;
   logic [2:0]           ty_ff, ty_in, tx_ff, tx_in;
   tap_tag_type          tag_ff, tag_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_filtered_ff, rsp_filtered_in;
   logic                 rsp_frame_end_ff, rsp_frame_end_in;

   logic [DIM_BITS-1:0]  eff_w, eff_h, fw_use, fh_use;
   logic                 frame_start, is_pix, all_in, emit, col_wrap, out_col_wrap;
   logic [DIM_BITS-1:0]  out_row_nx;
   logic [9:0]           pend_inc, lag1;
   logic                 wr_en, rd_en, ws_clear, ws_busy, div_start, div_done;
   logic [7:0]           rd_data, quot;
   logic [SW_BITS-1:0]   sum_w;
   logic [SWP_BITS-1:0]  sum_wp;
   logic signed [3:0]    dy, dx;
   logic [1:0]           ady, adx;
   logic [DIM_BITS-1:0]  rr, cc, rdiff;
   logic signed [4:0]    rt;
   logic [RING_BITS-1:0] rd_ring;
   logic                 out_free;

   always_comb begin
      eff_w = width_reg_ff;
      if (eff_w > DIM_BITS'(MAX_WIDTH)) eff_w = DIM_BITS'(MAX_WIDTH);
      if (eff_w < DIM_BITS'(MIN_DIM)) eff_w = DIM_BITS'(MIN_DIM);
      eff_h = (height_reg_ff < DIM_BITS'(MIN_DIM)) ? DIM_BITS'(MIN_DIM) : height_reg_ff;
   end

   assign frame_start  = (in_row_ff == '0) && (in_col_ff == '0);
   assign fw_use       = frame_start ? eff_w : frame_w_ff;
   assign fh_use       = frame_start ? eff_h : frame_h_ff;
   assign all_in       = in_row_ff >= frame_h_ff;
   assign is_pix       = (req_op == OP_PIXEL) && !all_in;
   assign col_wrap     = ({1'b0, in_col_ff} + 9'd1) >= fw_use;
   assign pend_inc     = pending_ff + 10'd1;
   assign lag1         = {fw_use, 1'b0} + 10'd3;
   assign emit         = is_pix ? (pend_inc >= lag1) : all_in;
   assign out_col_wrap = ({1'b0, out_col_ff} + 9'd1) >= fw_use;
   assign out_row_nx   = out_row_ff + (out_col_wrap ? 9'd1 : 9'd0);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // tap offsets; the centre is read first so the range weights can use it
   always_comb begin
      dy  = centre_ph_ff ? 4'sd0 : $signed({1'b0, ty_ff}) - 4'sd2;
      dx  = centre_ph_ff ? 4'sd0 : $signed({1'b0, tx_ff}) - 4'sd2;
      ady = (dy < 0) ? 2'(-dy) : 2'(dy);
      adx = (dx < 0) ? 2'(-dx) : 2'(dx);
      rr    = reflect_pos(job_row_ff, dy, frame_h_ff);
      cc    = reflect_pos({1'b0, job_col_ff}, dx, frame_w_ff);
      rdiff = rr - job_row_ff;
      rt    = $signed({2'b00, job_ring_ff}) + $signed({rdiff[3], rdiff[3:0]});
      if (rt < 0) rt = rt + 5'sd6;
      else if (rt >= 5'sd6) rt = rt - 5'sd6;
      rd_ring = rt[RING_BITS-1:0];
   end

   always_comb begin
      state_in         = state_ff;
      width_reg_in     = width_reg_ff;
      height_reg_in    = height_reg_ff;
      frame_w_in       = frame_w_ff;
      frame_h_in       = frame_h_ff;
      in_row_in        = in_row_ff;
      in_col_in        = in_col_ff;
      in_ring_in       = in_ring_ff;
      out_row_in       = out_row_ff;
      out_col_in       = out_col_ff;
      out_ring_in      = out_ring_ff;
      pending_in       = pending_ff;
      job_row_in       = job_row_ff;
      job_col_in       = job_col_ff;
      job_ring_in      = job_ring_ff;
      job_end_in       = job_end_ff;
      centre_ph_in     = centre_ph_ff;
      ty_in            = ty_ff;
      tx_in            = tx_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_filtered_in  = rsp_filtered_ff;
      rsp_frame_end_in = rsp_frame_end_ff;
      wr_en            = 1'b0;
      ws_clear         = 1'b0;
      div_start        = 1'b0;
      tag_in.valid     = state_ff == ST_READ;
      tag_in.centre    = centre_ph_ff;
      tag_in.d2        = D2_BITS'(ady * ady) + D2_BITS'(adx * adx);

      if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_reg_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_reg_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (is_pix) begin
                  wr_en = 1'b1;
                  if (frame_start) begin
                     frame_w_in = eff_w;
                     frame_h_in = eff_h;
                  end
                  if (col_wrap) begin
                     in_col_in  = '0;
                     in_row_in  = in_row_ff + 9'd1;
                     in_ring_in = ring_inc(in_ring_ff);
                  end else begin
                     in_col_in = in_col_ff + 1'b1;
                  end
                  if (!emit) pending_in = pend_inc;
               end else if (emit) begin
                  pending_in = pending_ff - 10'd1;
               end
               if (emit) begin
                  job_row_in   = out_row_ff;
                  job_col_in   = out_col_ff;
                  job_ring_in  = out_ring_ff;
                  job_end_in   = (out_row_ff == fh_use - 9'd1) &&
                                 ({1'b0, out_col_ff} == fw_use - 9'd1);
                  centre_ph_in = 1'b1;
                  ty_in        = '0;
                  tx_in        = '0;
                  ws_clear     = 1'b1;
                  state_in     = ST_READ;
                  if (out_col_wrap) begin
                     out_col_in  = '0;
                     out_row_in  = out_row_nx;
                     out_ring_in = ring_inc(out_ring_ff);
                  end else begin
                     out_col_in = out_col_ff + 1'b1;
                  end
                  // frame complete: the position counters and pending count restart
                  if (out_col_wrap && out_row_nx >= fh_use) begin
                     in_row_in   = '0;
                     in_col_in   = '0;
                     in_ring_in  = '0;
                     out_row_in  = '0;
                     out_col_in  = '0;
                     out_ring_in = '0;
                     pending_in  = '0;
                  end
               end
            end
         end
         ST_READ: begin
            if (centre_ph_ff) begin
               centre_ph_in = 1'b0;
            end else if (tx_ff == 3'd4) begin
               tx_in = '0;
               ty_in = ty_ff + 3'd1;
               if (ty_ff == 3'd4) state_in = ST_DRAIN;
            end else begin
               tx_in = tx_ff + 3'd1;
            end
         end
         ST_DRAIN: begin
            if (!tag_ff.valid && !ws_busy) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_filtered_in  = quot;
               rsp_frame_end_in = job_end_ff;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         width_reg_ff  <= DIM_BITS'(MAX_WIDTH);
         height_reg_ff <= DIM_BITS'(MAX_WIDTH);
         frame_w_ff    <= DIM_BITS'(MAX_WIDTH);
         frame_h_ff    <= DIM_BITS'(MAX_WIDTH);
         in_row_ff     <= '0;
         in_col_ff     <= '0;
         in_ring_ff    <= '0;
         out_row_ff    <= '0;
         out_col_ff    <= '0;
         out_ring_ff   <= '0;
         pending_ff    <= '0;
         centre_ph_ff  <= 1'b0;
         ty_ff         <= '0;
         tx_ff         <= '0;
         tag_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         width_reg_ff  <= width_reg_in;
         height_reg_ff <= height_reg_in;
         frame_w_ff    <= frame_w_in;
         frame_h_ff    <= frame_h_in;
         in_row_ff     <= in_row_in;
         in_col_ff     <= in_col_in;
         in_ring_ff    <= in_ring_in;
         out_row_ff    <= out_row_in;
         out_col_ff    <= out_col_in;
         out_ring_ff   <= out_ring_in;
         pending_ff    <= pending_in;
         centre_ph_ff  <= centre_ph_in;
         ty_ff         <= ty_in;
         tx_ff         <= tx_in;
         tag_ff        <= tag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_row_ff       <= job_row_in;
      job_col_ff       <= job_col_in;
      job_ring_ff      <= job_ring_in;
      job_end_ff       <= job_end_in;
      rsp_filtered_ff  <= rsp_filtered_in;
      rsp_frame_end_ff <= rsp_frame_end_in;
   end

   assign rd_en = state_ff == ST_READ;

   bf5_line_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr ({in_ring_ff, in_col_ff}),
      .wr_data (req_pixel),
      .rd_en   (rd_en),
      .rd_addr ({rd_ring, cc[COL_BITS-1:0]}),
      .rd_data (rd_data)
   );

   bf5_wsum u_wsum (
      .clock   (clock),
      .reset   (reset),
      .clear   (ws_clear),
      .tag     (tag_ff),
      .rd_data (rd_data),
      .busy    (ws_busy),
      .sum_w   (sum_w),
      .sum_wp  (sum_wp)
   );

   bf5_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (sum_wp),
      .den   (sum_w),
      .done  (div_done),
      .quot  (quot)
   );

   assign req_stall     = state_ff != ST_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = rsp_filtered_ff;
   assign rsp_frame_end = rsp_frame_end_ff;
   assign csr_ready     = 1'b1;

`ifndef NO_ASSERTIONS
   a_ring_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (rd_ring < RING_BITS'(RING_LINES)))
      else $error("line ring index out of range");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, in_col_ff} < frame_w_ff) && ({1'b0, out_col_ff} < frame_w_ff))
      else $error("column counter beyond frame width");

   a_out_behind: assert property (@(posedge clock) disable iff (reset)
      out_row_ff <= in_row_ff)
      else $error("output position ahead of input");

   a_div_to_out: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside its state");
`endif

endmodule
`default_nettype wire
